// File: sv/qzc_pkg.sv
// Shared types, widths, register codes and helpers for the quadratic root finder.
package qzc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Field widths
    localparam int DATA_W    = 32;
    localparam int TOL_W     = 31;
    localparam int CNT_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TOL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_TOL  = 2'd2;

    // Configuration reset values
    localparam logic [TOL_W-1:0] ZERO_TOL_RST = 31'd1;
    localparam logic [TOL_W-1:0] END_TOL_RST  = 31'd66;
    localparam logic [TOL_W-1:0] DUP_TOL_RST  = 31'd1;

    // Internal datapath widths
    localparam int PROD_W    = 64;  // 32 x 32 unsigned product
    localparam int DISC_W    = 66;  // b*b + 4*|a*c|
    localparam int SQ_STEPS  = 33;  // one root bit per step
    localparam int SQ_REM_W  = 36;
    localparam int SQ_ROOT_W = 33;
    localparam int SQ_W      = 34;  // rounded root
    localparam int NUM_W     = 35;  // signed numerator
    localparam int NM_W      = 34;  // numerator magnitude
    localparam int DM_W      = 33;  // divisor magnitude

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LINE,
        KIND_QUAD
    } t_kind;

    typedef struct packed {
        logic [TOL_W-1:0] zero_tol;
        logic [TOL_W-1:0] end_tol;
        logic [TOL_W-1:0] dup_tol;
    } t_cfg;

    // Sideband through the square root pipeline
    typedef struct packed {
        t_kind                    kind;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] s;
        logic signed [DATA_W-1:0] e;
    } t_sq_side;

    // Sideband through the divider pipeline
    typedef struct packed {
        t_kind                    kind;
        logic signed [DATA_W-1:0] s;
        logic signed [DATA_W-1:0] e;
    } t_div_side;

    // Magnitude of a 32-bit two's complement value
    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// File: sv/qzc_disc.sv
// Coefficient products, discriminant and case classification (two stages).
module qzc_disc import qzc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  t_cfg                     i_cfg,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    input  logic signed [DATA_W-1:0] i_c,
    input  logic signed [DATA_W-1:0] i_s,
    input  logic signed [DATA_W-1:0] i_e,
    output logic                     o_valid,
    output logic [DISC_W-1:0]        o_disc,
    output t_sq_side                 o_side
);

    // Stage 1: magnitudes, zero tests, products
    logic [DATA_W-1:0] w_ma, w_mb, w_mc;
    logic              w_a_small, w_b_small, w_ac_neg;

    assign w_ma      = mag32(i_a);
    assign w_mb      = mag32(i_b);
    assign w_mc      = mag32(i_c);
    assign w_a_small = (i_a == '0) || ({1'b0, i_cfg.zero_tol} > w_ma);
    assign w_b_small = (i_b == '0) || ({1'b0, i_cfg.zero_tol} > w_mb);
    assign w_ac_neg  = (i_a[DATA_W-1] != i_c[DATA_W-1]) && (i_a != '0) && (i_c != '0);

    logic                     r1_valid;
    logic [PROD_W-1:0]        r1_b2, r1_p;
    logic                     r1_ac_neg, r1_a_small, r1_b_small;
    logic signed [DATA_W-1:0] r1_a, r1_b, r1_c, r1_s, r1_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_b2      <= PROD_W'(w_mb) * PROD_W'(w_mb);
            r1_p       <= PROD_W'(w_ma) * PROD_W'(w_mc);
            r1_ac_neg  <= w_ac_neg;
            r1_a_small <= w_a_small;
            r1_b_small <= w_b_small;
            r1_a       <= i_a;
            r1_b       <= i_b;
            r1_c       <= i_c;
            r1_s       <= i_s;
            r1_e       <= i_e;
        end
    end

    // Stage 2: b*b -/+ 4*|a*c| and the kind of solution
    logic [DISC_W-1:0] w_b2x, w_p4, w_disc;
    logic              w_dneg;
    t_kind             w_kind;

    always_comb begin
        w_b2x  = {2'b00, r1_b2};
        w_p4   = {r1_p, 2'b00};
        w_dneg = !r1_ac_neg && (w_p4 > w_b2x);
        w_disc = r1_ac_neg ? (w_b2x + w_p4) : (w_b2x - w_p4);
        priority if (w_dneg) begin
            w_kind = KIND_NONE;
        end else if (r1_a_small) begin
            w_kind = r1_b_small ? KIND_NONE : KIND_LINE;
        end else begin
            w_kind = KIND_QUAD;
        end
    end

    logic     r2_valid;
    logic [DISC_W-1:0] r2_disc;
    t_sq_side r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_disc <= w_disc;
            r2_side <= '{kind: w_kind, a: r1_a, b: r1_b, c: r1_c, s: r1_s, e: r1_e};
        end
    end

    assign o_valid = r2_valid;
    assign o_disc  = r2_disc;
    assign o_side  = r2_side;

endmodule

// File: sv/qzc_sqrt.sv
// Pipelined integer square root, one root bit per stage, rounded to nearest.
module qzc_sqrt import qzc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DISC_W-1:0] i_disc,
    input  t_sq_side          i_side,
    output logic              o_valid,
    output logic [SQ_W-1:0]   o_sq,
    output t_sq_side          o_side
);

    logic                 r_v    [0:SQ_STEPS-1];
    logic [SQ_REM_W-1:0]  r_rem  [0:SQ_STEPS-1];
    logic [SQ_ROOT_W-1:0] r_root [0:SQ_STEPS-1];
    logic [DISC_W-1:0]    r_d    [0:SQ_STEPS-2];
    t_sq_side             r_sd   [0:SQ_STEPS-1];

    // Restoring square root, two radicand bits per stage from the top
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam int BIT = 2 * (SQ_STEPS - 1 - k);

        logic                 v_in;
        logic [SQ_REM_W-1:0]  rem_in, rem_x, trial;
        logic [SQ_ROOT_W-1:0] root_in;
        logic [DISC_W-1:0]    d_in;
        t_sq_side             sd_in;
        logic                 ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign d_in    = i_disc;
            assign sd_in   = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign d_in    = r_d[k-1];
            assign sd_in   = r_sd[k-1];
        end

        assign rem_x = {rem_in[SQ_REM_W-3:0], d_in[BIT+1:BIT]};
        assign trial = SQ_REM_W'({root_in, 2'b01});
        assign ge    = (rem_x >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (rem_x - trial) : rem_x;
                r_root[k] <= {root_in[SQ_ROOT_W-2:0], ge};
                r_sd[k]   <= sd_in;
            end
        end

        if (k < SQ_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d[k] <= d_in;
                end
            end
        end
    end

    // Round to nearest: bump the root when the remainder exceeds it
    logic            w_up;
    logic            r_ov;
    logic [SQ_W-1:0] r_sq;
    t_sq_side        r_oside;

    assign w_up = r_rem[SQ_STEPS-1] > SQ_REM_W'(r_root[SQ_STEPS-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[SQ_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq    <= SQ_W'(r_root[SQ_STEPS-1]) + SQ_W'(w_up);
            r_oside <= r_sd[SQ_STEPS-1];
        end
    end

    assign o_valid = r_ov;
    assign o_sq    = r_sq;
    assign o_side  = r_oside;

endmodule

// File: sv/qzc_div.sv
// Numerators, divisor and a two-lane pipelined rounding divider.
module qzc_div import qzc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int XW = NM_W + FRAC_BITS + 1,
    localparam int RW = XW + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [SQ_W-1:0]      i_sq,
    input  t_sq_side             i_side,
    output logic                 o_valid,
    output logic signed [RW-1:0] o_root0,
    output logic signed [RW-1:0] o_root1,
    output t_div_side            o_side
);

    localparam int STEPS = XW;

    // Stage P1: signed numerators, divisor magnitude and quotient signs
    logic signed [NUM_W-1:0] w_nb, w_nl, w_sqx, w_n0, w_n1;
    logic [NM_W-1:0]         w_nm0, w_nm1;
    logic [DM_W-1:0]         w_dm;
    logic                    w_dneg;

    always_comb begin
        w_nb  = -{{(NUM_W-DATA_W){i_side.b[DATA_W-1]}}, i_side.b};
        w_nl  = -{{(NUM_W-DATA_W){i_side.c[DATA_W-1]}}, i_side.c};
        w_sqx = {{(NUM_W-SQ_W){1'b0}}, i_sq};
        unique case (i_side.kind)
            KIND_QUAD: begin
                w_n0   = w_nb - w_sqx;
                w_n1   = w_nb + w_sqx;
                w_dm   = {mag32(i_side.a), 1'b0};
                w_dneg = i_side.a[DATA_W-1];
            end
            KIND_LINE: begin
                w_n0   = w_nl;
                w_n1   = '0;
                w_dm   = {1'b0, mag32(i_side.b)};
                w_dneg = i_side.b[DATA_W-1];
            end
            default: begin
                w_n0   = '0;
                w_n1   = '0;
                w_dm   = DM_W'(1);
                w_dneg = 1'b0;
            end
        endcase
        w_nm0 = w_n0[NUM_W-1] ? NM_W'(-w_n0) : NM_W'(w_n0);
        w_nm1 = w_n1[NUM_W-1] ? NM_W'(-w_n1) : NM_W'(w_n1);
    end

    logic            r1_v, r1_neg0, r1_neg1;
    logic [NM_W-1:0] r1_nm0, r1_nm1;
    logic [DM_W-1:0] r1_dm;
    t_div_side       r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_nm0  <= w_nm0;
            r1_nm1  <= w_nm1;
            r1_neg0 <= w_n0[NUM_W-1] ^ w_dneg;
            r1_neg1 <= w_n1[NUM_W-1] ^ w_dneg;
            r1_dm   <= w_dm;
            r1_side <= '{kind: i_side.kind, s: i_side.s, e: i_side.e};
        end
    end

    // Stage P2: scaled dividend plus half the divisor for rounding
    logic          r2_v, r2_neg0, r2_neg1;
    logic [XW-1:0] r2_x0, r2_x1;
    logic [DM_W-1:0] r2_dm;
    t_div_side     r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_x0   <= XW'({r1_nm0, {FRAC_BITS{1'b0}}}) + XW'(r1_dm >> 1);
            r2_x1   <= XW'({r1_nm1, {FRAC_BITS{1'b0}}}) + XW'(r1_dm >> 1);
            r2_neg0 <= r1_neg0;
            r2_neg1 <= r1_neg1;
            r2_dm   <= r1_dm;
            r2_side <= r1_side;
        end
    end

    // Restoring division, one quotient bit per stage; quotient shifts into x
    logic            r_dv   [0:STEPS-1];
    logic [XW-1:0]   r_x0   [0:STEPS-1];
    logic [XW-1:0]   r_x1   [0:STEPS-1];
    logic [DM_W-1:0] r_rem0 [0:STEPS-2];
    logic [DM_W-1:0] r_rem1 [0:STEPS-2];
    logic [DM_W-1:0] r_dmk  [0:STEPS-2];
    logic            r_ng0  [0:STEPS-1];
    logic            r_ng1  [0:STEPS-1];
    t_div_side       r_sd   [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic            v_in, ng0_in, ng1_in, ge0, ge1;
        logic [XW-1:0]   x0_in, x1_in;
        logic [DM_W-1:0] rem0_in, rem1_in, dm_in;
        logic [DM_W:0]   t0, t1, dmx;
        t_div_side       sd_in;

        if (k == 0) begin : g_first
            assign v_in    = r2_v;
            assign x0_in   = r2_x0;
            assign x1_in   = r2_x1;
            assign rem0_in = '0;
            assign rem1_in = '0;
            assign dm_in   = r2_dm;
            assign ng0_in  = r2_neg0;
            assign ng1_in  = r2_neg1;
            assign sd_in   = r2_side;
        end else begin : g_next
            assign v_in    = r_dv[k-1];
            assign x0_in   = r_x0[k-1];
            assign x1_in   = r_x1[k-1];
            assign rem0_in = r_rem0[k-1];
            assign rem1_in = r_rem1[k-1];
            assign dm_in   = r_dmk[k-1];
            assign ng0_in  = r_ng0[k-1];
            assign ng1_in  = r_ng1[k-1];
            assign sd_in   = r_sd[k-1];
        end

        assign dmx = {1'b0, dm_in};
        assign t0  = {rem0_in, x0_in[XW-1]};
        assign t1  = {rem1_in, x1_in[XW-1]};
        assign ge0 = (t0 >= dmx);
        assign ge1 = (t1 >= dmx);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (i_en) begin
                r_dv[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x0[k]  <= {x0_in[XW-2:0], ge0};
                r_x1[k]  <= {x1_in[XW-2:0], ge1};
                r_ng0[k] <= ng0_in;
                r_ng1[k] <= ng1_in;
                r_sd[k]  <= sd_in;
            end
        end

        if (k < STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem0[k] <= ge0 ? DM_W'(t0 - dmx) : DM_W'(t0);
                    r_rem1[k] <= ge1 ? DM_W'(t1 - dmx) : DM_W'(t1);
                    r_dmk[k]  <= dm_in;
                end
            end
        end
    end

    // Apply the quotient sign
    logic                 r_ov;
    logic signed [RW-1:0] r_root0, r_root1;
    t_div_side            r_oside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_dv[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root0 <= r_ng0[STEPS-1] ? -$signed({1'b0, r_x0[STEPS-1]})
                                      :  $signed({1'b0, r_x0[STEPS-1]});
            r_root1 <= r_ng1[STEPS-1] ? -$signed({1'b0, r_x1[STEPS-1]})
                                      :  $signed({1'b0, r_x1[STEPS-1]});
            r_oside <= r_sd[STEPS-1];
        end
    end

    assign o_valid = r_ov;
    assign o_root0 = r_root0;
    assign o_root1 = r_root1;
    assign o_side  = r_oside;

endmodule

// File: sv/qzc_sel.sv
// Interval test, endpoint snapping, sort, duplicate merge and saturated output.
module qzc_sel import qzc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int RW = NM_W + FRAC_BITS + 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [RW-1:0]     i_root0,
    input  logic signed [RW-1:0]     i_root1,
    input  t_div_side                i_side,
    input  t_cfg                     i_cfg,
    output logic                     o_valid,
    output logic [CNT_W-1:0]         o_root_count,
    output logic signed [DATA_W-1:0] o_first_root,
    output logic signed [DATA_W-1:0] o_second_root
);

    localparam int DW = RW + 1;
    localparam logic signed [RW-1:0] SAT_HI = {{(RW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO = {{(RW-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    function automatic logic signed [DW-1:0] ext(input logic signed [RW-1:0] v);
        return {v[RW-1], v};
    endfunction

    function automatic logic [DATA_W-1:0] sat(input logic signed [RW-1:0] v);
        logic [DATA_W-1:0] res;
        priority if (v > SAT_HI) begin
            res = SAT_HI[DATA_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[DATA_W-1:0];
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    // Stage S1: keep roots inside the interval, snap a line root to an end
    logic signed [RW-1:0] w_s, w_e, w_x0;
    logic signed [DW-1:0] w_ds, w_de, w_etp, w_etn;
    logic                 w_line, w_quad, w_close_s, w_close_e, w_in0, w_in1;

    always_comb begin
        w_s       = {{(RW-DATA_W){i_side.s[DATA_W-1]}}, i_side.s};
        w_e       = {{(RW-DATA_W){i_side.e[DATA_W-1]}}, i_side.e};
        w_ds      = ext(i_root0) - ext(w_s);
        w_de      = ext(i_root0) - ext(w_e);
        w_etp     = {{(DW-TOL_W){1'b0}}, i_cfg.end_tol};
        w_etn     = -w_etp;
        w_line    = (i_side.kind == KIND_LINE);
        w_quad    = (i_side.kind == KIND_QUAD);
        w_close_s = (w_ds < w_etp) && (w_ds > w_etn);
        w_close_e = (w_de < w_etp) && (w_de > w_etn);
        priority if (w_line && w_close_s) begin
            w_x0  = w_s;
            w_in0 = 1'b1;
        end else if (w_line && w_close_e) begin
            w_x0  = w_e;
            w_in0 = 1'b1;
        end else begin
            w_x0  = i_root0;
            w_in0 = (w_line || w_quad) && (w_s <= i_root0) && (i_root0 <= w_e);
        end
        w_in1 = w_quad && (w_s <= i_root1) && (i_root1 <= w_e);
    end

    logic                 r1_v, r1_in0, r1_in1;
    logic signed [RW-1:0] r1_x0, r1_x1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x0  <= w_x0;
            r1_x1  <= i_root1;
            r1_in0 <= w_in0;
            r1_in1 <= w_in1;
        end
    end

    // Stage S2: order the kept roots and merge a close pair
    logic signed [DW-1:0] w_dd, w_dtp, w_dtn;
    logic signed [RW-1:0] w_lo, w_hi;
    logic [CNT_W-1:0]     w_cnt;
    logic                 w_swap, w_near;

    always_comb begin
        w_dd   = ext(r1_x1) - ext(r1_x0);
        w_dtp  = {{(DW-TOL_W){1'b0}}, i_cfg.dup_tol};
        w_dtn  = -w_dtp;
        w_swap = (r1_x1 < r1_x0);
        w_near = (w_dd < w_dtp) && (w_dd > w_dtn);
        priority if (r1_in0 && r1_in1) begin
            w_lo  = w_swap ? r1_x1 : r1_x0;
            w_hi  = w_near ? '0 : (w_swap ? r1_x0 : r1_x1);
            w_cnt = w_near ? 2'd1 : 2'd2;
        end else if (r1_in0) begin
            w_lo  = r1_x0;
            w_hi  = '0;
            w_cnt = 2'd1;
        end else if (r1_in1) begin
            w_lo  = r1_x1;
            w_hi  = '0;
            w_cnt = 2'd1;
        end else begin
            w_lo  = '0;
            w_hi  = '0;
            w_cnt = 2'd0;
        end
    end

    logic                 r2_v;
    logic signed [RW-1:0] r2_lo, r2_hi;
    logic [CNT_W-1:0]     r2_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_lo  <= w_lo;
            r2_hi  <= w_hi;
            r2_cnt <= w_cnt;
        end
    end

    // Stage S3: output register with saturation to 32 bits
    logic                     r_ov;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [DATA_W-1:0] r_first, r_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cnt    <= r2_cnt;
            r_first  <= sat(r2_lo);
            r_second <= sat(r2_hi);
        end
    end

    assign o_valid       = r_ov;
    assign o_root_count  = r_cnt;
    assign o_first_root  = r_first;
    assign o_second_root = r_second;

endmodule

// File: sv/quadratic_zero_crossing_in_interval.sv
// Top level: real roots of a quadratic inside an interval, fully pipelined.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------
//  input    | i_valid / o_stall        | i_coef_a/b/c, i_interval_start/end
//  result   | o_valid / i_stall        | o_root_count, o_first_root, o_second_root
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item enters per cycle while no result is held back; pipeline depth is dominated
// by the 33 root steps of the square root and the FRAC_BITS + 35 divider steps.
// Synchronous active-low reset clears every stage valid bit and loads the
// tolerance registers with their defaults. A stalled result freezes the whole
// pipeline, and o_stall follows at once; config writes are always taken.
module quadratic_zero_crossing_in_interval import qzc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_coef_a,
    input  logic signed [DATA_W-1:0] i_coef_b,
    input  logic signed [DATA_W-1:0] i_coef_c,
    input  logic signed [DATA_W-1:0] i_interval_start,
    input  logic signed [DATA_W-1:0] i_interval_end,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [CNT_W-1:0]         o_root_count,
    output logic signed [DATA_W-1:0] o_first_root,
    output logic signed [DATA_W-1:0] o_second_root,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [TOL_W-1:0]         i_cfg_data
);

    localparam int RW = NM_W + FRAC_BITS + 2;

    // Tolerance registers
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{zero_tol: ZERO_TOL_RST, end_tol: END_TOL_RST, dup_tol: DUP_TOL_RST};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ZERO_TOL: r_cfg.zero_tol <= i_cfg_data;
                CFG_END_TOL:  r_cfg.end_tol  <= i_cfg_data;
                CFG_DUP_TOL:  r_cfg.dup_tol  <= i_cfg_data;
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // Pipeline advances unless a finished result is held back
    logic w_en;

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    logic              w_d_valid;
    logic [DISC_W-1:0] w_disc;
    t_sq_side          w_d_side;

    qzc_disc u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_cfg   (r_cfg),
        .i_a     (i_coef_a),
        .i_b     (i_coef_b),
        .i_c     (i_coef_c),
        .i_s     (i_interval_start),
        .i_e     (i_interval_end),
        .o_valid (w_d_valid),
        .o_disc  (w_disc),
        .o_side  (w_d_side)
    );

    logic            w_q_valid;
    logic [SQ_W-1:0] w_sq;
    t_sq_side        w_q_side;

    qzc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_valid),
        .i_disc  (w_disc),
        .i_side  (w_d_side),
        .o_valid (w_q_valid),
        .o_sq    (w_sq),
        .o_side  (w_q_side)
    );

    logic                 w_r_valid;
    logic signed [RW-1:0] w_root0, w_root1;
    t_div_side            w_r_side;

    qzc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_q_valid),
        .i_sq    (w_sq),
        .i_side  (w_q_side),
        .o_valid (w_r_valid),
        .o_root0 (w_root0),
        .o_root1 (w_root1),
        .o_side  (w_r_side)
    );

    qzc_sel #(.FRAC_BITS(FRAC_BITS)) u_sel (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_r_valid),
        .i_root0       (w_root0),
        .i_root1       (w_root1),
        .i_side        (w_r_side),
        .i_cfg         (r_cfg),
        .o_valid       (o_valid),
        .o_root_count  (o_root_count),
        .o_first_root  (o_first_root),
        .o_second_root (o_second_root)
    );

endmodule

// File: sv/qzc_chk.sv
// Port-level checks on the result channel, bound to the top level.
module qzc_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_root_count,
    input logic signed [31:0] o_first_root,
    input logic signed [31:0] o_second_root
);

    // A held result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // Count never exceeds two
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_root_count != 2'd3)
        else $error("root count out of range");

    // Unused root slots read zero
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_count != 2'd2 |-> o_second_root == 32'sd0)
        else $error("second root not zero");

    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_count == 2'd0 |-> o_first_root == 32'sd0)
        else $error("first root not zero");

    // Two roots come out in ascending order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_count == 2'd2 |-> o_first_root <= o_second_root)
        else $error("roots not sorted");

endmodule

bind quadratic_zero_crossing_in_interval qzc_chk u_qzc_chk (.*);
